// File: hw/rtl/olls_pkg.sv
`default_nettype none

package olls_pkg;

    localparam int NUM_REGISTERS_DEF = 128;

    localparam int CMD_W  = 1;
    localparam int RANK_W = 7;
    localparam int IDX_W  = 7;
    localparam int OFF_W  = 6;
    localparam int BASE_W = 8;
    localparam int CNT_W  = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 1'b1;

    localparam logic [BASE_W-1:0] OFFSET_LIMIT = 8'd63;
    localparam logic [BASE_W-1:0] BASE_MAX     = 8'd255;

    localparam logic [CNT_W-1:0] REGS_IN_USE_RESET = 8'd128;

endpackage

`default_nettype wire

// File: hw/rtl/olls_req_if.sv
`default_nettype none

interface olls_req_if;
    logic                          valid;
    logic                          ready;
    logic [olls_pkg::CMD_W-1:0]    command;
    logic [olls_pkg::RANK_W-1:0]   rank;
    logic [olls_pkg::IDX_W-1:0]    register_index;

    modport source (output valid, output command, output rank, output register_index,
                    input ready);
    modport sink   (input valid, input command, input rank, input register_index,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/olls_rsp_if.sv
`default_nettype none

interface olls_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olls_pkg::BASE_W-1:0]   base_offset;
    logic                          register_written;
    logic [olls_pkg::CNT_W-1:0]    zero_registers;

    modport source (output valid, output base_offset, output register_written,
                    output zero_registers, input ready);
    modport sink   (input valid, input base_offset, input register_written,
                    input zero_registers, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/olls_ram.sv
`default_nettype none

module olls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/offset_loglog_sketch_update.sv
// insert: result registered out of S_UPDATE or a rebase; next request taken only in S_IDLE
// rebase: each pass walks the registers in use through the store, decrementing nonzero entries
// clear command: sweeps n store entries, then gives a result
// the single-port-write store is the limit: one entry read and one written per cycle
// reset (sync, active low) and a config write start a clearing sweep of n entries, no requests taken
`default_nettype none

module offset_loglog_sketch_update #(
    parameter int NUM_REGISTERS = olls_pkg::NUM_REGISTERS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    olls_req_if.sink                        i_req,
    olls_rsp_if.source                      o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [olls_pkg::CNT_W-1:0] i_cfg_wdata
);

    localparam int AW    = $clog2(NUM_REGISTERS);
    localparam int NMAX  = (NUM_REGISTERS > 255) ? 255 : NUM_REGISTERS;
    localparam logic [olls_pkg::CNT_W-1:0] NMAX8 = olls_pkg::CNT_W'(NMAX);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_REBASE = 2'd3;

    function automatic logic [olls_pkg::CNT_W-1:0] f_clamp(input logic [olls_pkg::CNT_W-1:0] v);
        logic [olls_pkg::CNT_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = 8'd1;
        end else if (v > NMAX8) begin
            res = NMAX8;
        end
        return res;
    endfunction

    logic [1:0]                    r_state, n_state;
    logic [olls_pkg::CNT_W-1:0]    r_cfg, n_cfg;
    logic [olls_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_pend, n_pend;
    logic [AW-1:0]                 r_pend_addr, n_pend_addr;
    logic [olls_pkg::BASE_W-1:0]   r_base, n_base;
    logic [olls_pkg::CNT_W-1:0]    r_zero, n_zero;
    logic                          r_clr_out, n_clr_out;
    logic                          r_out_valid, n_out_valid;
    logic [olls_pkg::BASE_W-1:0]   r_out_base, n_out_base;
    logic                          r_out_written, n_out_written;
    logic [olls_pkg::CNT_W-1:0]    r_out_zero, n_out_zero;
    logic [olls_pkg::RANK_W-1:0]   r_rank, n_rank;
    logic [olls_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                          r_written, n_written;

    logic [olls_pkg::CNT_W-1:0]    w_n;
    logic                          w_in_ready;
    logic                          w_in_acc;
    logic [AW+olls_pkg::CNT_W-1:0] w_cnt_ext;
    logic [AW+olls_pkg::IDX_W-1:0] w_idx_ext;
    logic [AW+olls_pkg::IDX_W-1:0] w_in_idx_ext;
    logic [AW-1:0]                 w_cnt_addr;
    logic [AW-1:0]                 w_idx_addr;
    logic [AW-1:0]                 w_in_idx_addr;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [olls_pkg::OFF_W-1:0]    w_wdata;
    logic [AW-1:0]                 w_raddr;
    logic [olls_pkg::OFF_W-1:0]    w_rdata;
    logic [olls_pkg::BASE_W-1:0]   w_off;
    logic                          w_do_write;
    logic [olls_pkg::CNT_W-1:0]    w_zero_upd;
    logic [olls_pkg::OFF_W-1:0]    w_dec;

    assign w_n           = f_clamp(r_cfg);
    assign w_in_ready    = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_in_acc      = i_req.valid && w_in_ready;
    assign w_cnt_ext     = {{AW{1'b0}}, r_cnt};
    assign w_idx_ext     = {{AW{1'b0}}, r_idx};
    assign w_in_idx_ext  = {{AW{1'b0}}, i_req.register_index};
    assign w_cnt_addr    = w_cnt_ext[AW-1:0];
    assign w_idx_addr    = w_idx_ext[AW-1:0];
    assign w_in_idx_addr = w_in_idx_ext[AW-1:0];
    assign w_raddr       = (r_state == S_REBASE) ? w_cnt_addr : w_in_idx_addr;

    // insert evaluation on the entry read back
    assign w_off      = {1'b0, r_rank} - r_base;
    assign w_do_write = ({1'b0, r_idx} < w_n) && ({1'b0, r_rank} > r_base)
                        && (w_off > {2'b00, w_rdata}) && (w_off < olls_pkg::OFFSET_LIMIT);
    assign w_zero_upd = (w_do_write && (w_rdata == '0) && (r_zero != '0)) ? r_zero - 8'd1
                                                                         : r_zero;
    assign w_dec      = (w_rdata == '0) ? w_rdata : w_rdata - 6'd1;

    olls_ram #(
        .WIDTH (olls_pkg::OFF_W),
        .DEPTH (NUM_REGISTERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_cfg         = r_cfg;
        n_cnt         = r_cnt;
        n_pend        = r_pend;
        n_pend_addr   = r_pend_addr;
        n_base        = r_base;
        n_zero        = r_zero;
        n_clr_out     = r_clr_out;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_base    = r_out_base;
        n_out_written = r_out_written;
        n_out_zero    = r_out_zero;
        n_rank        = r_rank;
        n_idx         = r_idx;
        n_written     = r_written;
        w_we          = 1'b0;
        w_waddr       = w_cnt_addr;
        w_wdata       = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = w_cnt_addr;
                w_wdata = '0;
                if (r_cnt == w_n - 8'd1) begin
                    n_state = S_IDLE;
                    if (r_clr_out) begin
                        n_out_valid   = 1'b1;
                        n_out_base    = '0;
                        n_out_written = 1'b0;
                        n_out_zero    = w_n;
                    end
                end else begin
                    n_cnt = r_cnt + 8'd1;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_rank = i_req.rank;
                    n_idx  = i_req.register_index;
                    if (i_req.command == olls_pkg::CMD_CLEAR) begin
                        n_state   = S_CLEAR;
                        n_cnt     = '0;
                        n_base    = '0;
                        n_zero    = w_n;
                        n_clr_out = 1'b1;
                    end else begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                w_we      = w_do_write;
                w_waddr   = w_idx_addr;
                w_wdata   = w_off[olls_pkg::OFF_W-1:0];
                n_zero    = w_zero_upd;
                n_written = w_do_write;
                if ((w_zero_upd == '0) && (r_base != olls_pkg::BASE_MAX)) begin
                    n_state = S_REBASE;
                    n_base  = r_base + 8'd1;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                end else begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_base    = r_base;
                    n_out_written = w_do_write;
                    n_out_zero    = w_zero_upd;
                end
            end
            S_REBASE: begin
                // write back the entry read last cycle, read the next one
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_pend_addr;
                    w_wdata = w_dec;
                    if (w_dec == '0) begin
                        n_zero = r_zero + 8'd1;
                    end
                end
                if (r_cnt < w_n) begin
                    n_pend      = 1'b1;
                    n_pend_addr = w_cnt_addr;
                    n_cnt       = r_cnt + 8'd1;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && (r_cnt == w_n)) begin
                    if ((r_zero == '0) && (r_base != olls_pkg::BASE_MAX)) begin
                        n_base = r_base + 8'd1;
                        n_cnt  = '0;
                    end else begin
                        n_state       = S_IDLE;
                        n_out_valid   = 1'b1;
                        n_out_base    = r_base;
                        n_out_written = r_written;
                        n_out_zero    = r_zero;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (i_cfg_we) begin
            n_cfg     = i_cfg_wdata;
            n_state   = S_CLEAR;
            n_cnt     = '0;
            n_base    = '0;
            n_zero    = f_clamp(i_cfg_wdata);
            n_clr_out = 1'b0;
            n_pend    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= olls_pkg::REGS_IN_USE_RESET;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_base      <= '0;
            r_zero      <= f_clamp(olls_pkg::REGS_IN_USE_RESET);
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_base      <= n_base;
            r_zero      <= n_zero;
            r_clr_out   <= n_clr_out;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr   <= n_pend_addr;
        r_out_base    <= n_out_base;
        r_out_written <= n_out_written;
        r_out_zero    <= n_out_zero;
        r_rank        <= n_rank;
        r_idx         <= n_idx;
        r_written     <= n_written;
    end

    assign i_req.ready            = w_in_ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.base_offset      = r_out_base;
    assign o_rsp.register_written = r_out_written;
    assign o_rsp.zero_registers   = r_out_zero;

endmodule

`default_nettype wire

// File: hw/rtl/olls_checker.sv
`default_nettype none

module olls_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic [olls_pkg::BASE_W-1:0] i_rsp_base_offset,
    input wire logic                        i_rsp_register_written,
    input wire logic [olls_pkg::CNT_W-1:0]  i_rsp_zero_registers
);

    logic [1:0] r_open;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_req_valid && i_req_ready;
    assign w_out_acc = i_rsp_valid && i_rsp_ready;

    // requests taken minus results delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_open <= r_open + 2'd1;
        end else if (!w_in_acc && w_out_acc) begin
            r_open <= r_open - 2'd1;
        end
    end

    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open == 2'd0) || (r_open == 2'd1))
        else $error("more than one request open");

    a_no_rsp_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_open == 2'd1))
        else $error("result with no open request");

    a_rebase_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_base_offset != olls_pkg::BASE_MAX))
        |-> (i_rsp_zero_registers != '0))
        else $error("no zero register left below saturated base");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_base_offset) && $stable(i_rsp_register_written)
         && $stable(i_rsp_zero_registers)))
        else $error("stalled result changed");

endmodule

bind offset_loglog_sketch_update olls_checker u_olls_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_req_valid            (i_req.valid),
    .i_req_ready            (i_req.ready),
    .i_rsp_valid            (o_rsp.valid),
    .i_rsp_ready            (o_rsp.ready),
    .i_rsp_base_offset      (o_rsp.base_offset),
    .i_rsp_register_written (o_rsp.register_written),
    .i_rsp_zero_registers   (o_rsp.zero_registers)
);

`default_nettype wire

// File: dv/offset_loglog_sketch_update_test.sv
`timescale 1ns / 1ps

module offset_loglog_sketch_update_test;

    localparam int STALL_LIMIT = 40000;
    localparam int ITEMS_PER_PHASE = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [olls_pkg::CNT_W-1:0] cfg_wdata = '0;
    bit steady = 1'b0;
    int unsigned quiet_cycles = 0;

    olls_req_if req_ch();
    olls_rsp_if rsp_ch();

    offset_loglog_sketch_update dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    class sketch_mirror;
        typedef struct packed {
            logic [olls_pkg::BASE_W-1:0] base_offset;
            logic                        register_written;
            logic [olls_pkg::CNT_W-1:0]  zero_registers;
        } t_sketch_reply;

        logic [olls_pkg::OFF_W-1:0]  offsets [olls_pkg::NUM_REGISTERS_DEF];
        logic [olls_pkg::BASE_W-1:0] base;
        int unsigned                 zeros;
        logic [olls_pkg::CNT_W-1:0]  regs_in_use;
        t_sketch_reply               expected_replies [$];
        int unsigned                 mismatches;

        function new();
            regs_in_use = olls_pkg::REGS_IN_USE_RESET;
            mismatches = 0;
            clear_all();
        endfunction

        function int unsigned active_regs();
            int unsigned n;
            n = regs_in_use;
            if (n == 0) begin
                n = 1;
            end
            if (n > olls_pkg::NUM_REGISTERS_DEF) begin
                n = olls_pkg::NUM_REGISTERS_DEF;
            end
            return n;
        endfunction

        function void clear_all();
            foreach (offsets[i]) begin
                offsets[i] = '0;
            end
            base = '0;
            zeros = active_regs();
        endfunction

        function void apply_config(logic [olls_pkg::CNT_W-1:0] value);
            regs_in_use = value;
            clear_all();
        endfunction

        function void take_request(logic [olls_pkg::CMD_W-1:0] cmd,
                                   logic [olls_pkg::RANK_W-1:0] rank,
                                   logic [olls_pkg::IDX_W-1:0] idx);
            t_sketch_reply r;
            int unsigned   n;
            int            off;
            logic          written;
            n = active_regs();
            written = 1'b0;
            if (cmd == olls_pkg::CMD_CLEAR) begin
                clear_all();
            end else begin
                if (idx < n && rank > base) begin
                    off = int'(rank) - int'(base);
                    if (off > int'(offsets[idx]) && off < int'(olls_pkg::OFFSET_LIMIT)) begin
                        if (offsets[idx] == 0 && zeros > 0) begin
                            zeros--;
                        end
                        offsets[idx] = off[olls_pkg::OFF_W-1:0];
                        written = 1'b1;
                    end
                end
                // rebase while every register in use is nonzero
                for (int pass = 0; pass < int'(olls_pkg::OFFSET_LIMIT); pass++) begin
                    if (zeros != 0 || base >= olls_pkg::BASE_MAX) begin
                        break;
                    end
                    base++;
                    for (int i = 0; i < n; i++) begin
                        if (offsets[i] > 0) begin
                            offsets[i]--;
                        end
                        if (offsets[i] == 0) begin
                            zeros++;
                        end
                    end
                end
            end
            r.base_offset = base;
            r.register_written = written;
            r.zero_registers = zeros[olls_pkg::CNT_W-1:0];
            expected_replies.insert(expected_replies.size(), r);
        endfunction

        function void check_reply(logic [olls_pkg::BASE_W-1:0] base_offset,
                                  logic register_written,
                                  logic [olls_pkg::CNT_W-1:0] zero_registers);
            t_sketch_reply r;
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: base_offset %0d register_written %0d zero_registers %0d",
                       base_offset, register_written, zero_registers);
                mismatches++;
                return;
            end
            r = expected_replies.pop_front();
            if (base_offset !== r.base_offset) begin
                $error("base_offset: expected %0d, actual %0d", r.base_offset, base_offset);
                mismatches++;
            end
            if (register_written !== r.register_written) begin
                $error("register_written: expected %0d, actual %0d",
                       r.register_written, register_written);
                mismatches++;
            end
            if (zero_registers !== r.zero_registers) begin
                $error("zero_registers: expected %0d, actual %0d",
                       r.zero_registers, zero_registers);
                mismatches++;
            end
        endfunction
    endclass

    sketch_mirror mirror = new();

    initial begin
        forever #10 clk = ~clk;
    end

    // reply side: ready drops at random unless in the steady stretch
    always @(negedge clk) begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            mirror.check_reply(rsp_ch.base_offset, rsp_ch.register_written,
                               rsp_ch.zero_registers);
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("offset_loglog_sketch_update regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [olls_pkg::CMD_W-1:0] cmd,
                                input logic [olls_pkg::RANK_W-1:0] rank,
                                input logic [olls_pkg::IDX_W-1:0] idx);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 21) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.rank <= rank;
        req_ch.register_index <= idx;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        mirror.take_request(cmd, rank, idx);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (mirror.expected_replies.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic program_regs(input logic [olls_pkg::CNT_W-1:0] value);
        drain_replies();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        mirror.apply_config(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= olls_pkg::CNT_W'($urandom_range(255));
    endtask

    // mostly ranks just above the base at indexes in use, with some noise
    task automatic random_request();
        int unsigned                 pick;
        int unsigned                 n;
        int unsigned                 hi;
        logic [olls_pkg::CMD_W-1:0]  cmd;
        logic [olls_pkg::RANK_W-1:0] rank;
        logic [olls_pkg::IDX_W-1:0]  idx;
        pick = $urandom_range(99);
        n = mirror.active_regs();
        cmd = (pick < 4) ? olls_pkg::CMD_CLEAR : olls_pkg::CMD_INSERT;
        if (pick < 90) begin
            idx = olls_pkg::IDX_W'($urandom_range(n - 1));
        end else begin
            idx = olls_pkg::IDX_W'($urandom_range(127));
        end
        if (pick < 80 && mirror.base < 127) begin
            hi = mirror.base + 62;
            if (hi > 127) begin
                hi = 127;
            end
            rank = olls_pkg::RANK_W'($urandom_range(hi, mirror.base + 1));
        end else begin
            rank = olls_pkg::RANK_W'($urandom_range(127));
        end
        send_request(cmd, rank, idx);
    endtask

    initial begin
        logic [olls_pkg::CNT_W-1:0] phase_regs [10];
        req_ch.valid = 1'b0;
        req_ch.command = olls_pkg::CMD_INSERT;
        req_ch.rank = '0;
        req_ch.register_index = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset register count
        send_request(olls_pkg::CMD_INSERT, 7'd0, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd127, 7'd127);
        send_request(olls_pkg::CMD_INSERT, 7'd62, 7'd127);
        send_request(olls_pkg::CMD_INSERT, 7'd62, 7'd127);
        send_request(olls_pkg::CMD_INSERT, 7'd63, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd1, 7'd0);
        send_request(olls_pkg::CMD_CLEAR, 7'd127, 7'd127);
        send_request(olls_pkg::CMD_INSERT, 7'd5, 7'd64);

        // single register, every hit rebases
        program_regs(8'd1);
        send_request(olls_pkg::CMD_INSERT, 7'd5, 7'd1);
        send_request(olls_pkg::CMD_INSERT, 7'd5, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd127, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd67, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd67, 7'd127);
        send_request(olls_pkg::CMD_CLEAR, 7'd0, 7'd0);

        // zero count treated as one
        program_regs(8'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd62, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd124, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd127, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd127, 7'd0);

        // count above the store size
        program_regs(8'd255);
        send_request(olls_pkg::CMD_INSERT, 7'd10, 7'd127);
        send_request(olls_pkg::CMD_CLEAR, 7'd85, 7'd42);

        program_regs(8'd2);
        send_request(olls_pkg::CMD_INSERT, 7'd3, 7'd0);
        send_request(olls_pkg::CMD_INSERT, 7'd4, 7'd1);

        phase_regs = '{8'd2, 8'd1, 8'd6, 8'd128, 8'd3, 8'd0, 8'd17, 8'd200,
                       8'd1, 8'd1};
        phase_regs[8] = olls_pkg::CNT_W'($urandom_range(8, 1));
        phase_regs[9] = olls_pkg::CNT_W'($urandom_range(255, 1));
        foreach (phase_regs[p]) begin
            program_regs(phase_regs[p]);
            steady = (p == 4);
            repeat (ITEMS_PER_PHASE) begin
                random_request();
            end
            steady = 1'b0;
        end

        drain_replies();
        repeat (300) @(posedge clk);
        if (mirror.mismatches == 0) begin
            $display("offset_loglog_sketch_update regression: pass");
        end else begin
            $display("offset_loglog_sketch_update regression: fail");
        end
        $finish;
    end
endmodule

// File: offset_loglog_sketch_update.f
hw/rtl/olls_pkg.sv
hw/rtl/olls_req_if.sv
hw/rtl/olls_rsp_if.sv
hw/rtl/olls_ram.sv
hw/rtl/offset_loglog_sketch_update.sv
hw/rtl/olls_checker.sv
dv/offset_loglog_sketch_update_test.sv
